@@ hw/rtl/pvm_pkg.sv @@
// shared types and constants of the ramp voice mixer
`timescale 1ns / 1ps

package pvm_pkg;

    localparam int unsigned TICK_RATE  = 100000;
    localparam int unsigned MIN_FREQ   = 20;
    localparam int unsigned MAX_FREQ   = 20000;
    localparam int unsigned SAMPLE_MAX = 4095;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 5;
    localparam int FREQ_W   = 15;
    localparam int SAMPLE_W = 12;

    // divider widths: dividend covers the tick rate, divisor covers steps times frequency
    localparam int DVD_W = 17;
    localparam int DVS_W = 23;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SYNC  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [FREQ_W-1:0] freq;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TICK_RD,
        B_TICK_WB,
        B_TICK_MUL,
        B_TICK_OUT,
        B_SET_MUL,
        B_SET_MUL2,
        B_DIV_GO,
        B_DIV_WAIT,
        B_FILL,
        B_SET_FIN,
        B_CLEAR,
        B_SYNC
    } back_state_t;

    typedef enum logic [1:0] {
        PH_P,
        PH_S,
        PH_QR,
        PH_GAIN
    } div_phase_t;

endpackage

@@ hw/rtl/pvm_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pvm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pvm_pkg::DVD_W-1:0]  dividend,
    input  logic [pvm_pkg::DVS_W-1:0]  divisor,
    output logic [pvm_pkg::DVD_W-1:0]  quotient,
    output logic [pvm_pkg::DVS_W-1:0]  remainder,
    output logic                       done
);

    localparam int CNT_W = $clog2(pvm_pkg::DVD_W + 1);

    logic                      run_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;
    logic [pvm_pkg::DVD_W-1:0] quo_reg;
    logic [pvm_pkg::DVS_W-1:0] rem_reg;
    logic [pvm_pkg::DVS_W-1:0] dvs_reg;

    logic [pvm_pkg::DVS_W:0]   trial;
    logic                      fits;
    logic [pvm_pkg::DVS_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[pvm_pkg::DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pvm_pkg::DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[pvm_pkg::DVD_W-2:0], fits};
            rem_reg <= fits ? diff[pvm_pkg::DVS_W-1:0] : trial[pvm_pkg::DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ hw/rtl/pvm_queue.sv @@
// two-entry request queue between front and back
`timescale 1ns / 1ps

module pvm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pvm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output pvm_pkg::head_t head,
    output logic          full
);

    pvm_pkg::cmd_t entry_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wp_reg] <= push_cmd;
    end

    assign head.valid = cnt_reg != 2'd0;
    assign head.cmd   = entry_reg[rp_reg];
    assign full       = cnt_reg == 2'd2;

endmodule

@@ hw/rtl/pvm_front.sv @@
// front end: takes requests and drops those that change nothing
`timescale 1ns / 1ps

module pvm_front #(
    parameter int VOICES = 32
) (
    input  logic                        start,
    input  logic [pvm_pkg::OP_W-1:0]    operation,
    input  logic [pvm_pkg::SLOT_W-1:0]  slot,
    input  logic [pvm_pkg::FREQ_W-1:0]  frequency,
    input  logic                        full,
    output logic                        busy,
    output logic                        push,
    output pvm_pkg::cmd_t               push_cmd
);

    logic keep;
    logic slot_ok;
    logic freq_ok;

    always_comb
    begin
        slot_ok = int'(slot) < VOICES;
        freq_ok = (int'(frequency) >= int'(pvm_pkg::MIN_FREQ))
               && (int'(frequency) <= int'(pvm_pkg::MAX_FREQ));
        case (pvm_pkg::op_t'(operation))
            pvm_pkg::OP_SET:   keep = slot_ok && freq_ok;
            pvm_pkg::OP_CLEAR: keep = slot_ok;
            default:           keep = 1'b1;
        endcase
        push_cmd.op   = pvm_pkg::op_t'(operation);
        push_cmd.slot = slot;
        push_cmd.freq = frequency;
    end

    assign busy = full;
    assign push = start && !full && keep;

endmodule

@@ hw/rtl/pvm_back.sv @@
// back end: sequencer for tick walk, voice setup, clear and sync
`timescale 1ns / 1ps

module pvm_back #(
    parameter int VOICES = 32,
    parameter int STEPS  = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pvm_pkg::head_t                head,
    output logic                          pop,
    output logic [pvm_pkg::SAMPLE_W-1:0]  sample,
    output logic                          result_valid
);

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW    = $clog2(STEPS);
    localparam int PMAX  = pvm_pkg::TICK_RATE / (STEPS * pvm_pkg::MIN_FREQ) + 1;
    localparam int PW    = $clog2(PMAX + 1);
    localparam int CW    = $clog2(VOICES + 1);
    localparam int SUMW  = $clog2(VOICES * (STEPS - 1) + 1);
    localparam int MW    = (SUMW + CW > 13) ? SUMW + CW : 13;
    localparam int AW    = VW + SW;
    localparam int DEPTH = 1 << AW;

    pvm_pkg::back_state_t state_reg, state_next;
    pvm_pkg::div_phase_t  phase_reg;
    pvm_pkg::cmd_t        cmd_reg;

    logic          active_reg [VOICES];
    logic [PW-1:0] tc_reg     [VOICES];
    logic [PW-1:0] pl_reg     [VOICES];
    logic [SW-1:0] si_reg     [VOICES];
    logic [SW-1:0] sl_reg     [VOICES];
    logic [SW-1:0] level_reg  [VOICES];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] gain_reg;

    logic [VW-1:0]   v_reg;
    logic            wrap_reg;
    logic [SUMW-1:0] sum_reg;
    logic [MW-1:0]   mix_reg;

    logic [pvm_pkg::DVD_W-1:0] dvd_reg;
    logic [pvm_pkg::DVS_W-1:0] dvs_reg;
    logic [PW-1:0]   p_reg;
    logic [SW:0]     s_reg;
    logic [SW:0]     qs_reg;
    logic [SW:0]     rs_reg;
    logic [SW-1:0]   i_reg;
    logic [SW-1:0]   qacc_reg;
    logic [SW:0]     racc_reg;

    logic [SW-1:0] ramp_mem [DEPTH];
    logic [SW-1:0] rd_q;

    logic                      div_start;
    logic [pvm_pkg::DVD_W-1:0] div_q;
    logic [pvm_pkg::DVS_W-1:0] div_r;
    logic                      div_done;

    logic [VW-1:0] slot_idx;
    logic          hit;
    logic [SW-1:0] si_new;
    logic [SW:0]   racc_sum;
    logic [SW:0]   s_clamp;
    logic [SW-1:0] lv;
    logic [CW-1:0] count_new;
    logic          mem_we;

    pvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    always_comb
    begin
        slot_idx  = VW'(cmd_reg.slot);
        hit       = tc_reg[v_reg] == pl_reg[v_reg];
        si_new    = (si_reg[v_reg] >= sl_reg[v_reg]) ? '0 : si_reg[v_reg] + 1'b1;
        racc_sum  = racc_reg + rs_reg;
        s_clamp   = (div_q > pvm_pkg::DVD_W'(STEPS)) ? (SW + 1)'(STEPS) : div_q[SW:0];
        lv        = wrap_reg ? rd_q : level_reg[v_reg];
        count_new = active_reg[slot_idx] ? count_reg : count_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvm_pkg::B_IDLE:
                if (head.valid)
                begin
                    case (head.cmd.op)
                        pvm_pkg::OP_TICK:  state_next = pvm_pkg::B_TICK_RD;
                        pvm_pkg::OP_SET:   state_next = pvm_pkg::B_SET_MUL;
                        pvm_pkg::OP_CLEAR: state_next = pvm_pkg::B_CLEAR;
                        default:           state_next = pvm_pkg::B_SYNC;
                    endcase
                end
            pvm_pkg::B_TICK_RD:  state_next = pvm_pkg::B_TICK_WB;
            pvm_pkg::B_TICK_WB:
                state_next = (v_reg == VW'(VOICES - 1)) ? pvm_pkg::B_TICK_MUL
                                                        : pvm_pkg::B_TICK_RD;
            pvm_pkg::B_TICK_MUL: state_next = pvm_pkg::B_TICK_OUT;
            pvm_pkg::B_TICK_OUT: state_next = pvm_pkg::B_IDLE;
            pvm_pkg::B_SET_MUL:  state_next = pvm_pkg::B_DIV_GO;
            pvm_pkg::B_SET_MUL2: state_next = pvm_pkg::B_DIV_GO;
            pvm_pkg::B_DIV_GO:   state_next = pvm_pkg::B_DIV_WAIT;
            pvm_pkg::B_DIV_WAIT:
                if (div_done)
                begin
                    case (phase_reg)
                        pvm_pkg::PH_P:  state_next = pvm_pkg::B_SET_MUL2;
                        pvm_pkg::PH_S:  state_next = pvm_pkg::B_DIV_GO;
                        pvm_pkg::PH_QR: state_next = pvm_pkg::B_FILL;
                        default:        state_next = pvm_pkg::B_IDLE;
                    endcase
                end
            pvm_pkg::B_FILL:
                if ({1'b0, i_reg} == s_reg - 1'b1)
                    state_next = pvm_pkg::B_SET_FIN;
            pvm_pkg::B_SET_FIN:  state_next = pvm_pkg::B_DIV_GO;
            pvm_pkg::B_CLEAR:    state_next = pvm_pkg::B_IDLE;
            pvm_pkg::B_SYNC:     state_next = pvm_pkg::B_IDLE;
            default:             state_next = pvm_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop          = (state_reg == pvm_pkg::B_IDLE) && head.valid;
        div_start    = state_reg == pvm_pkg::B_DIV_GO;
        mem_we       = state_reg == pvm_pkg::B_FILL;
        result_valid = state_reg == pvm_pkg::B_TICK_OUT;
        sample       = (mix_reg > MW'(pvm_pkg::SAMPLE_MAX)) ? pvm_pkg::SAMPLE_W'(pvm_pkg::SAMPLE_MAX)
                                                           : mix_reg[pvm_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pvm_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    // voice state and mixer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VOICES; k++)
            begin
                active_reg[k] <= 1'b0;
                tc_reg[k]     <= '0;
                pl_reg[k]     <= '0;
                si_reg[k]     <= '0;
                sl_reg[k]     <= '0;
                level_reg[k]  <= '0;
            end
            count_reg <= '0;
            gain_reg  <= CW'(1);
            phase_reg <= pvm_pkg::PH_P;
            v_reg     <= '0;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                pvm_pkg::B_IDLE:
                    v_reg <= '0;
                pvm_pkg::B_TICK_RD:
                begin
                    wrap_reg <= active_reg[v_reg] && hit;
                    if (active_reg[v_reg])
                    begin
                        if (hit)
                        begin
                            tc_reg[v_reg] <= '0;
                            si_reg[v_reg] <= si_new;
                        end
                        else
                            tc_reg[v_reg] <= tc_reg[v_reg] + 1'b1;
                    end
                end
                pvm_pkg::B_TICK_WB:
                begin
                    if (wrap_reg)
                        level_reg[v_reg] <= rd_q;
                    v_reg <= v_reg + 1'b1;
                end
                pvm_pkg::B_SET_MUL:  phase_reg <= pvm_pkg::PH_P;
                pvm_pkg::B_SET_MUL2: phase_reg <= pvm_pkg::PH_S;
                pvm_pkg::B_DIV_WAIT:
                    if (div_done)
                    begin
                        if (phase_reg == pvm_pkg::PH_S)
                            phase_reg <= pvm_pkg::PH_QR;
                        else if (phase_reg == pvm_pkg::PH_GAIN)
                            gain_reg <= div_q[CW-1:0];
                    end
                pvm_pkg::B_SET_FIN:
                begin
                    tc_reg[slot_idx]     <= '0;
                    si_reg[slot_idx]     <= '0;
                    pl_reg[slot_idx]     <= p_reg - 1'b1;
                    sl_reg[slot_idx]     <= SW'(s_reg - 1'b1);
                    active_reg[slot_idx] <= 1'b1;
                    count_reg            <= count_new;
                    phase_reg            <= pvm_pkg::PH_GAIN;
                end
                pvm_pkg::B_CLEAR:
                begin
                    if (active_reg[slot_idx])
                        count_reg <= count_reg - 1'b1;
                    active_reg[slot_idx] <= 1'b0;
                    level_reg[slot_idx]  <= '0;
                    tc_reg[slot_idx]     <= '0;
                    si_reg[slot_idx]     <= '0;
                    sl_reg[slot_idx]     <= '0;
                    pl_reg[slot_idx]     <= '0;
                end
                pvm_pkg::B_SYNC:
                    for (int k = 0; k < VOICES; k++)
                    begin
                        tc_reg[k] <= '0;
                        si_reg[k] <= '0;
                    end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pvm_pkg::B_IDLE:
            begin
                cmd_reg <= head.cmd;
                sum_reg <= '0;
            end
            pvm_pkg::B_TICK_WB:  sum_reg <= sum_reg + SUMW'(lv);
            pvm_pkg::B_TICK_MUL: mix_reg <= MW'(sum_reg) * MW'(gain_reg);
            pvm_pkg::B_SET_MUL:
            begin
                dvd_reg <= pvm_pkg::DVD_W'(pvm_pkg::TICK_RATE);
                dvs_reg <= pvm_pkg::DVS_W'(cmd_reg.freq) * pvm_pkg::DVS_W'(STEPS);
            end
            pvm_pkg::B_SET_MUL2:
            begin
                dvd_reg <= pvm_pkg::DVD_W'(pvm_pkg::TICK_RATE);
                dvs_reg <= pvm_pkg::DVS_W'(cmd_reg.freq) * pvm_pkg::DVS_W'(p_reg);
            end
            pvm_pkg::B_DIV_WAIT:
                if (div_done)
                begin
                    case (phase_reg)
                        pvm_pkg::PH_P: p_reg <= PW'(div_q + 1'b1);
                        pvm_pkg::PH_S:
                        begin
                            s_reg   <= s_clamp;
                            dvd_reg <= pvm_pkg::DVD_W'(STEPS);
                            dvs_reg <= pvm_pkg::DVS_W'(s_clamp);
                        end
                        pvm_pkg::PH_QR:
                        begin
                            qs_reg   <= div_q[SW:0];
                            rs_reg   <= div_r[SW:0];
                            i_reg    <= '0;
                            qacc_reg <= '0;
                            racc_reg <= '0;
                        end
                        default: ;
                    endcase
                end
            pvm_pkg::B_FILL:
            begin
                // level i*steps/s built up as running quotient and remainder
                i_reg <= i_reg + 1'b1;
                if (racc_sum >= s_reg)
                begin
                    racc_reg <= racc_sum - s_reg;
                    qacc_reg <= SW'(qacc_reg + qs_reg + 1'b1);
                end
                else
                begin
                    racc_reg <= racc_sum;
                    qacc_reg <= SW'(qacc_reg + qs_reg);
                end
            end
            pvm_pkg::B_SET_FIN:
            begin
                dvd_reg <= pvm_pkg::DVD_W'(VOICES);
                dvs_reg <= pvm_pkg::DVS_W'(count_new);
            end
            default: ;
        endcase
    end

    // ramp table: one write port for the fill, one registered read for the tick walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ramp_mem[{slot_idx, i_reg}] <= qacc_reg;
        rd_q <= ramp_mem[{v_reg, si_new}];
    end

endmodule

@@ hw/rtl/polyphonic_ramp_voice_mixer.sv @@
// top level of the polyphonic ramp voice mixer
`timescale 1ns / 1ps

// bank of VOICES sawtooth voices driven by requests on start/busy.  a request is taken
// when start is high and busy is low, and busy rises only while the two-entry queue
// is full.  a tick request walks the voices one at a time through the shared
// ramp table port, reading and then writing back each voice, then multiplies by
// the gain; the back end takes its next request only after its sample has been
// shown.  the sample is shown for one cycle with result_valid high and cannot be
// held off, so the receiver must take it then.  set voice runs four passes of the
// shared divider (tick period, step count, fill increment, gain), and writes the
// ramp table one entry a cycle, one entry per step of the voice, between the fill
// increment and gain passes.  requests that change nothing are dropped at the front.
// the ramp table needs no clearing pass: an entry is read only after set voice
// has written it.

module polyphonic_ramp_voice_mixer #(
    parameter int VOICES = 32,
    parameter int STEPS  = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pvm_pkg::OP_W-1:0]      operation,
    input  logic [pvm_pkg::SLOT_W-1:0]    slot,
    input  logic [pvm_pkg::FREQ_W-1:0]    frequency,
    output logic [pvm_pkg::SAMPLE_W-1:0]  sample,
    output logic                          result_valid
);

    // front to queue
    logic          push;
    pvm_pkg::cmd_t push_cmd;
    logic          full;

    // queue to back
    pvm_pkg::head_t head;
    logic           pop;

    // classify and drop out-of-range slots and frequencies
    pvm_front #(
        .VOICES (VOICES)
    ) u_front (
        .start     (start),
        .operation (operation),
        .slot      (slot),
        .frequency (frequency),
        .full      (full),
        .busy      (busy),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // short queue so the front keeps taking requests while the back works
    pvm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full)
    );

    // voice state, ramp table, divider and mixer
    pvm_back #(
        .VOICES (VOICES),
        .STEPS  (STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .sample       (sample),
        .result_valid (result_valid)
    );

endmodule

@@ bench/tb.sv @@
// testbench of the polyphonic ramp voice mixer: own voice bank model and random requests
`timescale 1ns / 1ps

// tracks the voice bank from accepted requests and holds the samples that ticks must produce
class voice_bank_scoreboard;
    bit          active [32];
    int unsigned tick_cnt [32];
    int unsigned period_lim [32];
    int unsigned step_idx [32];
    int unsigned step_lim [32];
    logic [6:0]  level [32];
    logic [6:0]  ramp [32][128];
    int unsigned voice_total;
    int unsigned gain;
    logic [pvm_pkg::SAMPLE_W-1:0] expected_samples [$];
    int unsigned errors;
    int unsigned ticks_seen;
    int unsigned sets_taken;
    int unsigned clears_taken;
    int unsigned syncs_taken;

    function new();
        for (int v = 0; v < 32; v++)
        begin
            active[v]     = 0;
            tick_cnt[v]   = 0;
            period_lim[v] = 0;
            step_idx[v]   = 0;
            step_lim[v]   = 0;
            level[v]      = '0;
            for (int i = 0; i < 128; i++)
                ramp[v][i] = '0;
        end
        voice_total  = 0;
        gain         = 1;
        errors       = 0;
        ticks_seen   = 0;
        sets_taken   = 0;
        clears_taken = 0;
        syncs_taken  = 0;
    endfunction

    // advance every active voice and work out the mixed sample
    function logic [pvm_pkg::SAMPLE_W-1:0] mix_tick();
        int unsigned sum;
        int unsigned mixed;
        sum = 0;
        for (int v = 0; v < 32; v++)
        begin
            if (active[v])
            begin
                if (tick_cnt[v] == period_lim[v])
                begin
                    tick_cnt[v] = 0;
                    if (step_idx[v] >= step_lim[v])
                        step_idx[v] = 0;
                    else
                        step_idx[v]++;
                    level[v] = ramp[v][step_idx[v] % 128];
                end
                else
                    tick_cnt[v]++;
            end
            sum += 32'(level[v]);
        end
        mixed = sum * gain;
        if (mixed > pvm_pkg::SAMPLE_MAX)
            mixed = pvm_pkg::SAMPLE_MAX;
        return pvm_pkg::SAMPLE_W'(mixed);
    endfunction

    function void note_request(pvm_pkg::op_t op, int unsigned v, int unsigned f);
        int unsigned p;
        int unsigned s;
        case (op)
            pvm_pkg::OP_TICK:
            begin
                expected_samples.push_back(mix_tick());
                ticks_seen++;
            end
            pvm_pkg::OP_SET:
            begin
                if (f >= pvm_pkg::MIN_FREQ && f <= pvm_pkg::MAX_FREQ)
                begin
                    p = pvm_pkg::TICK_RATE / (128 * f) + 1;
                    s = pvm_pkg::TICK_RATE / (p * f);
                    if (s > 128)
                        s = 128;
                    for (int unsigned i = 0; i < s; i++)
                        ramp[v][i] = 7'((i * 128) / s);
                    tick_cnt[v]   = 0;
                    step_idx[v]   = 0;
                    period_lim[v] = p - 1;
                    step_lim[v]   = (s != 0) ? s - 1 : 0;
                    if (!active[v])
                    begin
                        active[v] = 1;
                        voice_total++;
                    end
                    gain = 32 / voice_total;
                    sets_taken++;
                end
            end
            pvm_pkg::OP_CLEAR:
            begin
                if (active[v])
                    voice_total--;
                active[v]     = 0;
                level[v]      = '0;
                tick_cnt[v]   = 0;
                step_idx[v]   = 0;
                step_lim[v]   = 0;
                period_lim[v] = 0;
                for (int i = 0; i < 128; i++)
                    ramp[v][i] = '0;
                clears_taken++;
            end
            default:
            begin
                for (int i = 0; i < 32; i++)
                begin
                    tick_cnt[i] = 0;
                    step_idx[i] = 0;
                end
                syncs_taken++;
            end
        endcase
    endfunction

    function void check_sample(logic [pvm_pkg::SAMPLE_W-1:0] got);
        logic [pvm_pkg::SAMPLE_W-1:0] want;
        if (expected_samples.size() == 0)
        begin
            $error("sample %0d arrived with no tick outstanding", got);
            errors++;
            return;
        end
        want = expected_samples.pop_front();
        if (got !== want)
        begin
            $error("sample mismatch: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [pvm_pkg::OP_W-1:0]        operation;
    logic [pvm_pkg::SLOT_W-1:0]      slot;
    logic [pvm_pkg::FREQ_W-1:0]      frequency;
    logic [pvm_pkg::SAMPLE_W-1:0]    sample;
    logic                            result_valid;

    voice_bank_scoreboard sb;
    int unsigned          cycles = 0;
    bit                   idling_on;

    polyphonic_ramp_voice_mixer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .slot         (slot),
        .frequency    (frequency),
        .sample       (sample),
        .result_valid (result_valid)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results first, then the request taken at this edge; both see pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_sample(sample);
            if (start && !busy)
                sb.note_request(pvm_pkg::op_t'(operation), 32'(slot), 32'(frequency));
        end
    end

    // watchdog against a stuck handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_request(pvm_pkg::op_t op, int unsigned v, int unsigned f);
        start     <= 1'b1;
        operation <= op;
        slot      <= pvm_pkg::SLOT_W'(v);
        frequency <= pvm_pkg::FREQ_W'(f);
        do
            @(posedge clk);
        while (busy);
    endtask

    // random sender gap, skipped in the closing stretch
    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned f;
        sb        = new();
        idling_on = 1;
        start     = 1'b0;
        operation = pvm_pkg::OP_TICK;
        slot      = '0;
        frequency = '0;
        rst_n     = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty bank, rejected frequencies, range edges, both slot ends
        send_request(pvm_pkg::OP_TICK, 0, 0);
        send_request(pvm_pkg::OP_SYNC, 0, 0);
        send_request(pvm_pkg::OP_CLEAR, 7, 0);
        send_request(pvm_pkg::OP_SET, 3, 19);
        send_request(pvm_pkg::OP_SET, 3, 20001);
        send_request(pvm_pkg::OP_SET, 3, 0);
        send_request(pvm_pkg::OP_SET, 3, 32767);
        send_request(pvm_pkg::OP_TICK, 0, 32767);
        send_request(pvm_pkg::OP_SET, 0, 20);
        send_request(pvm_pkg::OP_SET, 31, 20000);
        send_request(pvm_pkg::OP_SET, 16, 5461);
        repeat (6)
            send_request(pvm_pkg::OP_TICK, 31, 0);
        send_request(pvm_pkg::OP_SET, 31, 12345);
        send_request(pvm_pkg::OP_TICK, 0, 0);
        send_request(pvm_pkg::OP_SYNC, 31, 20000);
        send_request(pvm_pkg::OP_TICK, 0, 0);
        send_request(pvm_pkg::OP_CLEAR, 31, 0);
        send_request(pvm_pkg::OP_CLEAR, 31, 0);
        send_request(pvm_pkg::OP_TICK, 0, 0);

        // let everything settle once before the random part
        drain_results();

        for (int n = 0; n < 500; n++)
        begin
            if (n == 450)
                idling_on = 0;
            if (n == 250)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_request(pvm_pkg::OP_TICK, $urandom, $urandom);
            else if (pick < 84)
            begin
                // mostly fast voices so the ramps wrap within the run
                case ($urandom_range(0, 9))
                    0:       f = $urandom_range(0, 32767);
                    1:       f = $urandom_range(20, 400);
                    default: f = $urandom_range(1000, 20000);
                endcase
                send_request(pvm_pkg::OP_SET, $urandom_range(0, 31), f);
            end
            else if (pick < 94)
                send_request(pvm_pkg::OP_CLEAR, $urandom_range(0, 31), $urandom);
            else
                send_request(pvm_pkg::OP_SYNC, $urandom, $urandom);
            maybe_idle();
        end

        drain_results();
        // a trailing set voice may still be filling its table
        repeat (600)
            @(posedge clk);

        $display("covered %0d ticks, %0d voice sets, %0d clears and %0d syncs",
                 sb.ticks_seen, sb.sets_taken, sb.clears_taken, sb.syncs_taken);
        if (sb.errors == 0 && sb.expected_samples.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
